[rtl/core/iba_pkg.sv]
`timescale 1ns / 1ps

package iba_pkg;

    // Field widths fixed by the transaction format
    localparam int SIZE_W = 6;
    localparam int HINT_W = 5;
    localparam int BLK_W  = 5;
    localparam int FILE_W = 4;
    localparam int ST_W   = 2;
    localparam int CNT_W  = 6;   // holds a block count up to 32

    // Largest bitmap the block numbering can address
    localparam int MAX_MAP_W = 32;

    // Defaults for the top-level parameters
    localparam int DEF_NUM_BLOCKS = 32;
    localparam int DEF_MAX_FILES  = 10;

    // Configuration register
    localparam int                 CFG_DATA_W     = 32;
    localparam int                 CFG_ADDR_W     = 3;
    localparam logic               REG_BLOCKS_USE = 1'b0;   // register index 0
    localparam logic [CNT_W-1:0]   BIU_RESET      = 6'd32;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_NOFILE  = 2'd2;

    typedef struct packed {
        logic [SIZE_W-1:0] data_block_count;
        logic [HINT_W-1:0] index_hint;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [BLK_W-1:0]  block_number;
        logic              is_index_block;
        logic [FILE_W-1:0] file_number;
        logic              last;
    } t_rsp;

    // Control from the register file to the engine
    typedef struct packed {
        logic             restart;
        logic [CNT_W-1:0] restart_n;
        logic [CNT_W-1:0] n_eff;
    } t_cfg;

    // One result handed to the output register
    typedef struct packed {
        logic valid;
        t_rsp rsp;
    } t_emit;

    // Engine bookkeeping, visible to the top level for checks
    typedef struct packed {
        logic [CNT_W-1:0]  free_count;
        logic [FILE_W-1:0] files;
    } t_eng_stat;

    function automatic int map_width(input int nb);
        return (nb > MAX_MAP_W) ? MAX_MAP_W : nb;
    endfunction

endpackage

[rtl/core/iba_stream_if.sv]
`timescale 1ns / 1ps

interface iba_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/iba_engine.sv]
`timescale 1ns / 1ps

module iba_engine import iba_pkg::*; #(
    parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
    parameter int MAX_FILES  = DEF_MAX_FILES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_req_valid,
    input  t_req              i_req,
    output logic              o_req_ready,
    input  logic              i_emit_ok,
    output t_emit             o_emit,
    output t_eng_stat         o_stat
);

    localparam int MAP_W = map_width(NUM_BLOCKS);
    localparam int IDX_W = $clog2(MAP_W);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_MOD   = 5'b00100,
        S_IDX   = 5'b01000,
        S_DATA  = 5'b10000
    } t_state;

    t_state            r_state,      n_state;
    logic [MAP_W-1:0]  r_free_map,   n_free_map;
    logic [CNT_W-1:0]  r_free_count, n_free_count;
    logic [FILE_W-1:0] r_files,      n_files;
    logic [SIZE_W-1:0] r_size,       n_size;
    logic [SIZE_W-1:0] r_taken,      n_taken;
    logic [BLK_W-1:0]  r_pos,        n_pos;

    logic [MAP_W-1:0]  restart_mask;
    logic [6:0]        alu_b;
    logic [6:0]        alu_sum;
    logic              pos_in;
    logic              free_bit;
    logic              last_data;

    // free mask for a fresh start with restart_n blocks
    always_comb begin
        for (int b = 0; b < MAP_W; b++) begin
            restart_mask[b] = (CNT_W'(b) < i_cfg.restart_n);
        end
    end

    // shared add unit: subtract n during the modulo, else step by one
    assign alu_b   = (r_state == S_MOD) ? (7'd0 - {1'b0, i_cfg.n_eff}) : 7'd1;
    assign alu_sum = {2'b00, r_pos} + alu_b;

    assign pos_in    = ({1'b0, r_pos} < i_cfg.n_eff);
    assign free_bit  = pos_in && r_free_map[r_pos[IDX_W-1:0]];
    assign last_data = ((r_taken + SIZE_W'(1)) == r_size);

    always_comb begin
        n_state      = r_state;
        n_free_map   = r_free_map;
        n_free_count = r_free_count;
        n_files      = r_files;
        n_size       = r_size;
        n_taken      = r_taken;
        n_pos        = r_pos;
        o_emit       = '0;
        o_req_ready  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_size  = i_req.data_block_count;
                    n_pos   = BLK_W'(i_req.index_hint);
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_emit.rsp.file_number = r_files;
                o_emit.rsp.last        = 1'b1;
                if (r_files >= FILE_W'(MAX_FILES)) begin
                    o_emit.rsp.status = ST_NOFILE;
                    if (i_emit_ok) begin
                        o_emit.valid = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if ({1'b0, r_free_count} < ({1'b0, r_size} + 7'd1)) begin
                    o_emit.rsp.status = ST_NOSPACE;
                    if (i_emit_ok) begin
                        o_emit.valid = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (!alu_sum[6]) begin
                    n_pos = alu_sum[BLK_W-1:0];
                end else begin
                    n_state = S_IDX;
                end
            end
            S_IDX: begin
                o_emit.rsp.status         = ST_OK;
                o_emit.rsp.block_number   = r_pos;
                o_emit.rsp.is_index_block = 1'b1;
                o_emit.rsp.file_number    = r_files;
                o_emit.rsp.last           = (r_size == '0);
                if (free_bit) begin
                    if (i_emit_ok) begin
                        o_emit.valid                    = 1'b1;
                        n_free_map[r_pos[IDX_W-1:0]]    = 1'b0;
                        n_free_count                    = r_free_count - CNT_W'(1);
                        n_pos                           = '0;
                        n_taken                         = '0;
                        if (r_size == '0) begin
                            n_files = r_files + FILE_W'(1);
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_DATA;
                        end
                    end
                end else if (alu_sum[5:0] == i_cfg.n_eff) begin
                    n_pos = '0;
                end else begin
                    n_pos = alu_sum[BLK_W-1:0];
                end
            end
            S_DATA: begin
                o_emit.rsp.status       = ST_OK;
                o_emit.rsp.block_number = r_pos;
                o_emit.rsp.file_number  = r_files;
                o_emit.rsp.last         = last_data;
                if (free_bit) begin
                    if (i_emit_ok) begin
                        o_emit.valid                 = 1'b1;
                        n_free_map[r_pos[IDX_W-1:0]] = 1'b0;
                        n_free_count                 = r_free_count - CNT_W'(1);
                        n_taken                      = r_taken + SIZE_W'(1);
                        n_pos                        = alu_sum[BLK_W-1:0];
                        if (last_data) begin
                            n_files = r_files + FILE_W'(1);
                            n_state = S_IDLE;
                        end
                    end
                end else begin
                    n_pos = alu_sum[BLK_W-1:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg.restart) begin
            n_free_map   = restart_mask;
            n_free_count = i_cfg.restart_n;
            n_files      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_map   <= '1;
            r_free_count <= CNT_W'(MAP_W);
            r_files      <= '0;
        end else begin
            r_state      <= n_state;
            r_free_map   <= n_free_map;
            r_free_count <= n_free_count;
            r_files      <= n_files;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size  <= n_size;
        r_taken <= n_taken;
        r_pos   <= n_pos;
    end

    assign o_stat.free_count = r_free_count;
    assign o_stat.files      = r_files;

endmodule

[rtl/core/indexed_block_allocator.sv]
`timescale 1ns / 1ps

// Indexed block allocator: serves file allocation transactions against a
// free-block bitmap.
// i_req (sink) carries data_block_count and index_hint; o_rsp (source)
// returns one transaction per granted block: the index block first, then
// the data blocks in ascending order, last set on the final one. A request
// that fails the file-limit or free-space check returns a single status
// transaction and changes nothing.
// Config: one APB register, blocks_in_use at byte address 0. Writing it
// frees the blocks below the written count (clipped to the bitmap, zero
// as one), marks the rest used and clears the file count. Write only while idle.
// Per request: a check state, then hint mod n by repeated subtraction,
// then a bitmap probe per step of the index search (up to n probes) and
// of the data scan (up to n). Cost is set by the single shared adder
// stepping the bitmap position. i_req.ready is high only while idle.
// The output register lets the sequencer run ahead by one result; while
// o_rsp is stalled with a result held, the sequencer waits at its next
// grant. After reset all blocks are free, blocks_in_use is 32 and no file
// is allocated.
module indexed_block_allocator import iba_pkg::*; #(
    parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
    parameter int MAX_FILES  = DEF_MAX_FILES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    iba_stream_if.sink            i_req,
    iba_stream_if.source          o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int MAP_W = map_width(NUM_BLOCKS);

    logic [CNT_W-1:0] r_biu;
    logic             r_out_valid;
    t_rsp             r_out;

    logic             cfg_wr;
    logic [CNT_W-1:0] wr_n;
    logic [CNT_W-1:0] cur_n;
    t_cfg             cfg;
    t_emit            emit;
    t_eng_stat        stat;
    logic             emit_ok;
    logic             req_ready;

    // Effective block count: clip to the bitmap, zero counts as one
    function automatic logic [CNT_W-1:0] eff_n(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if (r > CNT_W'(MAP_W)) begin
            r = CNT_W'(MAP_W);
        end
        if (r == '0) begin
            r = CNT_W'(1);
        end
        return r;
    endfunction

    // APB: zero wait states, register index = paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_BLOCKS_USE);
    assign prdata = (paddr[2] == REG_BLOCKS_USE) ?
                    {{(CFG_DATA_W-CNT_W){1'b0}}, r_biu} : '0;

    assign wr_n  = eff_n(pwdata[CNT_W-1:0]);
    assign cur_n = eff_n(r_biu);

    assign cfg.restart   = cfg_wr;
    assign cfg.restart_n = wr_n;
    assign cfg.n_eff     = cur_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_biu <= BIU_RESET;
        end else if (cfg_wr) begin
            r_biu <= pwdata[CNT_W-1:0];
        end
    end

    // Output register: reload when empty or being drained this cycle
    assign emit_ok = !r_out_valid || o_rsp.ready;

    iba_engine #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .MAX_FILES  (MAX_FILES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req_valid (i_req.valid),
        .i_req       (i_req.data),
        .o_req_ready (req_ready),
        .i_emit_ok   (emit_ok),
        .o_emit      (emit),
        .o_stat      (stat)
    );

    assign i_req.ready = req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_out <= emit.rsp;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // Rejections are single, terminal and carry no block
    a_reject_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != ST_OK)) |->
        (r_out.last && (r_out.block_number == '0) && !r_out.is_index_block))
        else $error("rejection result malformed");

    // A new result only lands when the register can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |-> !emit.valid)
        else $error("result overwritten while stalled");

    // Free count never exceeds the managed block count
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cfg_wr |=> (stat.free_count <= cur_n))
        else $error("free count above block count");

    // File count never passes the limit
    a_file_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.files <= FILE_W'(MAX_FILES))
        else $error("file count above limit");

endmodule
